### src/assert_macros.svh
// Assertion macros for the row balancer RTL, included by grb_ctrl.
// Each macro expects signals named clk and rst in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define GRB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define GRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/grb_pkg.sv
// Shared constants and types of the greedy row balancer.
// No dependencies; imported by grb_ctrl, the top level and the testbench.
`default_nettype none

package grb_pkg;

  // Parameter defaults
  localparam int MAX_ROWS_DEF       = 16;
  localparam int MAX_ITEMS_DEF      = 128;
  localparam int ROW_WIDTH_BITS_DEF = 16;

  // Fixed field widths
  localparam int ITEM_W    = 12;
  localparam int ROWCNT_W  = 5;
  localparam int PAD_W     = 8;
  localparam int CHOSEN_W  = 4;
  localparam int NUMBER_W  = 7;
  localparam int WIDEST_W  = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_AMOUNT = 1'd1;

  // Reset values of configuration registers
  localparam logic [ROWCNT_W-1:0] ROW_COUNT_RST  = 5'd1;
  localparam logic [PAD_W-1:0]    PAD_AMOUNT_RST = 8'd4;

  // One result item
  typedef struct packed {
    logic                set_done;
    logic [WIDEST_W-1:0] widest_row;
    logic [NUMBER_W-1:0] item_number;
    logic [CHOSEN_W-1:0] chosen_row;
  } result_t;

endpackage

`default_nettype wire

### src/grb_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module grb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/grb_ctrl.sv
// Sequencer of the row balancer: set-start sweep, minimum scan over the row
// memory, saturating write-back and result build. Uses grb_pkg, grb_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module grb_ctrl #(
  parameter int MAX_ROWS       = 16,
  parameter int MAX_ITEMS      = 128,
  parameter int ROW_WIDTH_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 idle,
  input  wire logic [grb_pkg::ITEM_W-1:0]      item_width,
  input  wire logic                            first_item,
  input  wire logic                            last_item,
  input  wire logic [grb_pkg::ROWCNT_W-1:0]    row_count,
  input  wire logic [grb_pkg::PAD_W-1:0]       pad_amount,
  output logic                                 res_valid,
  input  wire logic                            res_ready,
  output grb_pkg::result_t                     res
);
  import grb_pkg::*;

  localparam int RIDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CNT_W  = $clog2(MAX_ROWS + 1);
  localparam int ICNT_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int RW     = ROW_WIDTH_BITS;
  localparam int SUM_W  = RW + 14;
  localparam logic [RW-1:0] WMAX = {RW{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE, S_SWEEP, S_SCAN, S_WRITE, S_RESULT
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    nrows;
  logic [ITEM_W-1:0]   width_q;
  logic                last_q;
  logic [PAD_W-1:0]    pad_q;
  logic [RIDX_W-1:0]   wa;
  logic [CNT_W-1:0]    ra;
  logic                rd_pend;
  logic [RIDX_W-1:0]   rd_idx;
  logic [RW-1:0]       best_val;
  logic [RIDX_W-1:0]   best_idx;
  logic [RW-1:0]       rmax;
  logic [ICNT_W-1:0]   icnt;

  logic                ram_we;
  logic [RIDX_W-1:0]   ram_waddr;
  logic [RW-1:0]       ram_wdata;
  logic                ram_re;
  logic [RW-1:0]       ram_rdata;
  logic [SUM_W-1:0]    sum;
  logic [RW-1:0]       new_val;
  logic [RW-1:0]       rmax_next;
  logic [31:0]         n_use;
  logic [31:0]         icnt_inc;
  logic [ICNT_W-1:0]   icnt_next;

  // Clamp the row count into 1..MAX_ROWS
  always_comb begin
    if (row_count == '0) begin
      n_use = 32'd1;
    end else if (32'(row_count) > MAX_ROWS) begin
      n_use = MAX_ROWS;
    end else begin
      n_use = 32'(row_count);
    end
  end

  // Saturating grow of the chosen row
  always_comb begin
    sum     = SUM_W'(best_val) + SUM_W'(width_q) + SUM_W'(pad_q);
    new_val = (sum > SUM_W'(WMAX)) ? WMAX : sum[RW-1:0];
    rmax_next = (new_val > rmax) ? new_val : rmax;
  end

  // Item counter advance with wrap and set end
  always_comb begin
    icnt_inc = 32'(icnt) + 32'd1;
    if (last_q || icnt_inc >= MAX_ITEMS) begin
      icnt_next = '0;
    end else begin
      icnt_next = icnt_inc[ICNT_W-1:0];
    end
  end

  // Memory port control
  always_comb begin
    ram_we    = (state == S_SWEEP) || (state == S_WRITE);
    ram_waddr = (state == S_SWEEP) ? wa : best_idx;
    ram_wdata = (state == S_SWEEP) ? RW'(pad_q) : new_val;
    ram_re    = (state == S_SCAN) && (ra < nrows);
  end

  grb_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_ROWS)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ra[RIDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_RESULT);

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rmax    <= '0;
      icnt    <= '0;
      rd_pend <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            nrows   <= CNT_W'(n_use);
            width_q <= item_width;
            last_q  <= last_item;
            pad_q   <= pad_amount;
            wa      <= '0;
            ra      <= '0;
            rd_pend <= 1'b0;
            if (first_item) begin
              rmax  <= RW'(pad_amount);
              icnt  <= '0;
              state <= S_SWEEP;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SWEEP: begin
          // Restart every row at the padding
          wa <= wa + RIDX_W'(1);
          if (wa == RIDX_W'(MAX_ROWS - 1)) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Issue reads, then track the lowest row as data returns
          if (ra < nrows) begin
            ra <= ra + CNT_W'(1);
          end
          rd_pend <= (ra < nrows);
          rd_idx  <= ra[RIDX_W-1:0];
          if (rd_pend) begin
            if (rd_idx == '0 || ram_rdata < best_val) begin
              best_val <= ram_rdata;
              best_idx <= rd_idx;
            end
            if (CNT_W'(rd_idx) == nrows - CNT_W'(1)) begin
              state <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          // Write back the grown row and build the result
          rmax             <= rmax_next;
          icnt             <= icnt_next;
          res.chosen_row   <= CHOSEN_W'(32'(best_idx));
          res.item_number  <= NUMBER_W'(32'(icnt));
          res.widest_row   <= WIDEST_W'(32'(rmax_next));
          res.set_done     <= last_q;
          rd_pend          <= 1'b0;
          state            <= S_RESULT;
        end
        S_RESULT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `GRB_ASSERT_NEXT(a_write_to_result, state == S_WRITE, state == S_RESULT,
    "write-back not followed by result")
  `GRB_ASSERT_NOW(a_best_in_range, state == S_WRITE, CNT_W'(best_idx) < nrows,
    "chosen row outside rows in use")
  `GRB_ASSERT_NEXT(a_max_covers_write, state == S_WRITE, rmax >= $past(new_val),
    "running maximum below written row")
  `GRB_ASSERT_NOW(a_read_only_scan, ram_re, state == S_SCAN && !ram_we,
    "row read outside scan")

endmodule

`default_nettype wire

### src/greedy_row_balancer_core.sv
// Greedy row balancer, top level: configuration registers, sequencer and
// output register. Depends on grb_pkg, grb_ctrl and grb_ram.
//
// Usage:
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   row_count (index 0) and pad_amount (index 1); cfg_ready is always high.
//   Write only while no request is in flight.
//   Input requests arrive on s_t*: item width in s_tdata, first-of-set flag
//   in s_tuser, last-of-set flag in s_tlast. Each request gives one result
//   on m_t*: chosen row, item number and widest row in m_tdata, set end on
//   m_tlast.
//   Sequence: a request is taken while idle, then the row memory is scanned
//   at one read per row in use, followed by one write-back and a result
//   state. A request marking the first of a set first runs a sweep that
//   writes the padding into every row of the memory.
//   The output register lets the next request be taken while a result
//   waits; if the receiver stalls, the sequencer holds its finished result
//   and stops taking requests until the output register frees.
//   Reset clears the sequencer, running maximum and item counter and loads
//   row_count = 1, pad_amount = 4. The row memory is not cleared; it is
//   filled on the first request of a set.
`default_nettype none

module greedy_row_balancer_core #(
  parameter int MAX_ROWS       = grb_pkg::MAX_ROWS_DEF,
  parameter int MAX_ITEMS      = grb_pkg::MAX_ITEMS_DEF,
  parameter int ROW_WIDTH_BITS = grb_pkg::ROW_WIDTH_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Configuration write channel
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [grb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [grb_pkg::CFG_DAT_W-1:0]  cfg_data,
  // Input stream
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [15:0]                    s_tdata,  // [11:0] item_width, [15:12] zero
  input  wire logic                           s_tuser,  // [0] first_item
  input  wire logic                           s_tlast,  // last_item
  // Output stream
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic      [31:0]                    m_tdata,  // [3:0] chosen_row,
                                                        // [10:4] item_number,
                                                        // [26:11] widest_row,
                                                        // [31:27] zero
  output logic                                m_tlast   // set_done
);
  import grb_pkg::*;

  logic [ROWCNT_W-1:0] row_count;
  logic [PAD_W-1:0]    pad_amount;
  logic                start;
  logic                idle;
  logic                res_valid;
  logic                res_ready;
  result_t             res;
  result_t             out_q;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count  <= ROW_COUNT_RST;
      pad_amount <= PAD_AMOUNT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ROW_COUNT:  row_count  <= cfg_data[ROWCNT_W-1:0];
        CFG_PAD_AMOUNT: pad_amount <= cfg_data[PAD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign s_tready  = idle;
  assign start     = s_tvalid && idle;
  assign res_ready = !m_tvalid || m_tready;

  grb_ctrl #(
    .MAX_ROWS       (MAX_ROWS),
    .MAX_ITEMS      (MAX_ITEMS),
    .ROW_WIDTH_BITS (ROW_WIDTH_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .idle       (idle),
    .item_width (s_tdata[ITEM_W-1:0]),
    .first_item (s_tuser),
    .last_item  (s_tlast),
    .row_count  (row_count),
    .pad_amount (pad_amount),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // Output register: load a finished result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_tdata = {5'd0, out_q.widest_row, out_q.item_number, out_q.chosen_row};
  assign m_tlast = out_q.set_done;

endmodule

`default_nettype wire

### tb/greedy_row_balancer_core_tb.sv
// Self-checking testbench for greedy_row_balancer_core: directed and random item
// streams with random idling on both sides, checked against an in-bench predictor.
// Depends on grb_pkg and the greedy_row_balancer_core RTL.
`default_nettype none

module greedy_row_balancer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import grb_pkg::*;

  localparam int N_ROWS       = MAX_ROWS_DEF;
  localparam int N_ITEMS      = MAX_ITEMS_DEF;
  localparam int WIDTH_SAT    = (1 << ROW_WIDTH_BITS_DEF) - 1;
  localparam int SETTLE_CYCLES = 2 * N_ROWS + 8;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #10 clk = ~clk;

  // Block ports
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [15:0]          s_tdata   = '0;
  logic                 s_tuser   = 1'b0;
  logic                 s_tlast   = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [31:0]          m_tdata;
  logic                 m_tlast;

  greedy_row_balancer_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  // Predictor state: row widths, running maximum, item counter and registers
  int unsigned     row_load [N_ROWS];
  int unsigned     widest_so_far = 0;
  int unsigned     set_position  = 0;
  logic [4:0]      rows_reg      = ROW_COUNT_RST;
  logic [7:0]      pad_reg       = PAD_AMOUNT_RST;

  result_t         pending_placements [$];
  int              mismatch_count = 0;

  // Idling controls
  bit              quiet_src = 1'b0;
  bit              quiet_snk = 1'b0;
  int              hold_left = 0;

  initial begin
    foreach (row_load[i]) row_load[i] = 0;
  end

  function automatic int unsigned sat_width(int unsigned v);
    return (v > WIDTH_SAT) ? WIDTH_SAT : v;
  endfunction

  // Place one item on the least loaded row and return the result it yields
  function automatic result_t place_item(logic [11:0] width, bit first, bit last);
    result_t     res;
    int unsigned rows;
    int unsigned best;
    if (first) begin
      foreach (row_load[i]) row_load[i] = 32'(pad_reg);
      widest_so_far = 32'(pad_reg);
      set_position  = 0;
    end
    rows = 32'(rows_reg);
    if (rows < 1) rows = 1;
    if (rows > N_ROWS) rows = N_ROWS;
    best = 0;
    for (int r = 1; r < rows; r++) begin
      if (row_load[r] < row_load[best]) best = r;
    end
    row_load[best] = sat_width(sat_width(row_load[best] + 32'(width)) + 32'(pad_reg));
    if (row_load[best] > widest_so_far) widest_so_far = row_load[best];
    res.chosen_row  = best[CHOSEN_W-1:0];
    res.item_number = set_position[NUMBER_W-1:0];
    res.widest_row  = widest_so_far[WIDEST_W-1:0];
    res.set_done    = last;
    set_position = set_position + 1;
    if (set_position >= N_ITEMS) set_position = 0;
    if (last) set_position = 0;
    return res;
  endfunction

  // Offer one request, wait for it to be taken, then predict its result
  task automatic send_item(logic [11:0] width, bit first, bit last);
    int gap;
    if (!quiet_src && $urandom_range(0, 39) == 0) quiet_src = 1'b1;
    else if (quiet_src && $urandom_range(0, 19) == 0) quiet_src = 1'b0;
    gap = quiet_src ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, width};
    s_tuser  <= first;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    pending_placements.insert(pending_placements.size(), place_item(width, first, last));
  endtask

  // Stop offering and wait until every expected result has come back
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_placements.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one configuration register while the block is idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_ROW_COUNT) rows_reg = value[4:0];
    else pad_reg = value;
  endtask

  function automatic logic [11:0] pick_width();
    case ($urandom_range(0, 7))
      0:       return 12'hFFF;
      1:       return 12'h000;
      2, 3:    return 12'($urandom_range(0, 63));
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  // Receiver: random stalls, quiet stretches and the requested long hold-off
  initial begin : result_sink
    int n;
    forever begin
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        while (hold_left > 0) begin
          @(posedge clk);
          hold_left--;
        end
      end
      if (!quiet_snk && $urandom_range(0, 29) == 0) quiet_snk = 1'b1;
      else if (quiet_snk && $urandom_range(0, 19) == 0) quiet_snk = 1'b0;
      n = quiet_snk ? 0 : $urandom_range(0, 3);
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready) && hold_left == 0);
    end
  end

  // Compare every accepted result with the oldest expectation
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.chosen_row  = m_tdata[3:0];
      got.item_number = m_tdata[10:4];
      got.widest_row  = m_tdata[26:11];
      got.set_done    = m_tlast;
      if (pending_placements.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: row %0d number %0d widest %0d done %0d",
                   got.chosen_row, got.item_number, got.widest_row, got.set_done);
      end else begin
        want = pending_placements.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: row %0d/%0d number %0d/%0d widest %0d/%0d done %0d/%0d",
                     want.chosen_row, got.chosen_row, want.item_number, got.item_number,
                     want.widest_row, got.widest_row, want.set_done, got.set_done);
        end
      end
    end
  end

  // Extremes, ties, row count limits, saturation and a row count change mid-set
  task automatic test_directed();
    send_item(12'd0, 1'b1, 1'b0);
    send_item(12'hFFF, 1'b0, 1'b0);
    send_item(12'd17, 1'b0, 1'b1);
    // rows kept across a set end
    send_item(12'd5, 1'b0, 1'b1);
    write_reg(CFG_ROW_COUNT, 8'd16);
    write_reg(CFG_PAD_AMOUNT, 8'd0);
    send_item(12'd0, 1'b1, 1'b0);
    send_item(12'd0, 1'b0, 1'b0);
    send_item(12'hFFF, 1'b0, 1'b0);
    send_item(12'd1, 1'b0, 1'b1);
    // zero rows behaves as one row; saturate it with wide items
    write_reg(CFG_ROW_COUNT, 8'd0);
    write_reg(CFG_PAD_AMOUNT, 8'd255);
    for (int i = 0; i < 16; i++) send_item(12'hFFF, i == 0, i == 15);
    // too many rows is clipped; upper data bits are ignored
    write_reg(CFG_ROW_COUNT, 8'd31);
    send_item(12'd100, 1'b1, 1'b0);
    send_item(12'd50, 1'b0, 1'b0);
    write_reg(CFG_ROW_COUNT, 8'hE3);
    send_item(12'd7, 1'b0, 1'b0);
    send_item(12'd9, 1'b0, 1'b1);
  endtask

  // One long set so that the item number wraps
  task automatic test_counter_wrap();
    write_reg(CFG_ROW_COUNT, 8'd4);
    write_reg(CFG_PAD_AMOUNT, 8'd1);
    for (int i = 0; i < N_ITEMS + 12; i++)
      send_item(12'($urandom_range(0, 255)), i == 0, i == N_ITEMS + 11);
  endtask

  // Random configurations, mostly well-formed sets, some stray flags
  task automatic test_random();
    int          sent;
    int          len;
    logic [4:0]  rows;
    logic [7:0]  pad;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       rows = 5'd1;
        1:       rows = 5'd16;
        2:       rows = 5'd0;
        3:       rows = 5'd31;
        default: rows = 5'($urandom_range(1, 16));
      endcase
      case (phase % 3)
        0:       pad = 8'd0;
        1:       pad = 8'd255;
        default: pad = 8'($urandom_range(0, 255));
      endcase
      write_reg(CFG_ROW_COUNT, {3'($urandom_range(0, 7)), rows});
      write_reg(CFG_PAD_AMOUNT, pad);
      sent = 0;
      while (sent < 120) begin
        if ($urandom_range(0, 99) < 85) begin
          len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
          for (int i = 0; i < len; i++) send_item(pick_width(), i == 0, i == len - 1);
          sent += len;
        end else begin
          send_item(pick_width(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          sent++;
        end
      end
    end
  endtask

  // Receiver holds off for a long stretch while requests keep coming
  task automatic test_backpressure();
    write_reg(CFG_ROW_COUNT, 8'd6);
    write_reg(CFG_PAD_AMOUNT, 8'd3);
    hold_left = 400;
    for (int i = 0; i < 40; i++) send_item(pick_width(), i % 10 == 0, i % 10 == 9);
  endtask

  // Sender pauses until the block has fully drained, then resumes the set
  task automatic test_sender_pause();
    write_reg(CFG_ROW_COUNT, 8'd9);
    for (int i = 0; i < 10; i++) send_item(pick_width(), i == 0, 1'b0);
    wait_idle();
    for (int i = 0; i < 10; i++) send_item(pick_width(), 1'b0, i == 9);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_counter_wrap();
    test_random();
    test_backpressure();
    test_sender_pause();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
+incdir+src
src/grb_pkg.sv
src/grb_ram.sv
src/grb_ctrl.sv
src/greedy_row_balancer_core.sv
tb/greedy_row_balancer_core_tb.sv
